@@ rtl/lsm_pkg.sv @@
// Package: shared types, constants and command/status bundles for the sample marker.
`default_nettype none
package lsm_pkg;

  localparam int BLOCK_LEN  = 32;
  localparam int POS_BITS   = 32;
  localparam int DATA_BITS  = 32;
  localparam int VAL_BITS   = (POS_BITS < DATA_BITS) ? POS_BITS : DATA_BITS;
  localparam int STEP_BITS  = (VAL_BITS > 1) ? $clog2(VAL_BITS) : 1;
  localparam int OFF_BITS   = 6;
  localparam int CNT_BITS   = $clog2(BLOCK_LEN + 1);
  localparam int IDX_BITS   = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int ADDR_BITS  = 3;

  localparam logic KIND_MARK   = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  localparam logic REG_SAMPLE_INTERVAL = 1'b0;
  localparam logic [DATA_BITS-1:0] SAMPLE_INTERVAL_RESET = 32'd32;

  typedef struct packed {
    logic [DATA_BITS-1:0] sa_value;
    logic                 block_last;
  } in_t;

  typedef struct packed {
    logic                 kind;
    logic                 mark_bit;
    logic [OFF_BITS-1:0]  bwt_offset;
    logic [DATA_BITS-1:0] orig_sample;
    logic                 last;
  } out_t;

  typedef struct packed {
    logic [OFF_BITS-1:0]  offset;
    logic [DATA_BITS-1:0] quotient;
  } record_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mark_emit;
    logic drain_read;
    logic drain_emit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
    logic drain_next;
    logic drain_last;
  } status_t;

endpackage
`default_nettype wire

@@ rtl/lsm_ctrl.sv @@
// Controller: sequences accept, serial divide, mark transfer and record drain.
`default_nettype none
module lsm_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire lsm_pkg::status_t status,
  output lsm_pkg::cmd_t        cmd
);

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_DIV       = 5'b00010,
    S_MARK      = 5'b00100,
    S_DRAIN_RD  = 5'b01000,
    S_DRAIN_OUT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = S_MARK;
        end
      end
      S_MARK: begin
        if (status.out_free) begin
          cmd.mark_emit = 1'b1;
          state_next    = status.drain_next ? S_DRAIN_RD : S_IDLE;
        end
      end
      S_DRAIN_RD: begin
        cmd.drain_read = 1'b1;
        state_next     = S_DRAIN_OUT;
      end
      S_DRAIN_OUT: begin
        if (status.out_free) begin
          cmd.drain_emit = 1'b1;
          state_next     = status.drain_last ? S_IDLE : S_DRAIN_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/lsm_dpath.sv @@
// Datapath: restoring divider, block counters, record store and output register.
`default_nettype none
module lsm_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lsm_pkg::cmd_t                 cmd,
  output lsm_pkg::status_t                   status,
  input  wire lsm_pkg::in_t                  in_data,
  input  wire logic [lsm_pkg::DATA_BITS-1:0] sample_interval,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output lsm_pkg::out_t                      out_data
);

  logic [lsm_pkg::VAL_BITS-1:0]  quo;
  logic [lsm_pkg::DATA_BITS-1:0] rem;
  logic [lsm_pkg::STEP_BITS-1:0] step;
  logic                          blk_last;
  logic [lsm_pkg::OFF_BITS-1:0]  item_index;
  logic [lsm_pkg::CNT_BITS-1:0]  record_count;
  logic [lsm_pkg::CNT_BITS-1:0]  rd_idx;
  lsm_pkg::record_t              rd_data;
  lsm_pkg::record_t              mem [lsm_pkg::BLOCK_LEN];

  logic [lsm_pkg::DATA_BITS:0]   trial;
  logic                          fits;
  logic [lsm_pkg::DATA_BITS-1:0] rem_step;
  logic                          marked;
  logic                          store;
  logic [lsm_pkg::CNT_BITS-1:0]  count_add;
  logic                          closing;
  logic [lsm_pkg::DATA_BITS-1:0] quo_ext;

  assign trial    = {rem, quo[lsm_pkg::VAL_BITS-1]};
  assign fits     = trial >= {1'b0, sample_interval};
  assign rem_step = fits ? lsm_pkg::DATA_BITS'(trial - {1'b0, sample_interval})
                         : lsm_pkg::DATA_BITS'(trial);
  assign quo_ext  = lsm_pkg::DATA_BITS'(quo);

  assign marked    = (sample_interval != '0) && (rem == '0);
  assign store     = marked && (record_count < lsm_pkg::CNT_BITS'(lsm_pkg::BLOCK_LEN));
  assign count_add = record_count + lsm_pkg::CNT_BITS'(store);
  assign closing   = blk_last ||
                     (({1'b0, item_index} + (lsm_pkg::OFF_BITS + 1)'(1))
                      >= (lsm_pkg::OFF_BITS + 1)'(lsm_pkg::BLOCK_LEN));

  always_comb begin
    status.div_done   = (step == lsm_pkg::STEP_BITS'(lsm_pkg::VAL_BITS - 1));
    status.out_free   = !out_valid || out_ready;
    status.drain_next = closing && (count_add != '0);
    status.drain_last = (rd_idx + lsm_pkg::CNT_BITS'(1)) == record_count;
  end

  // divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo      <= in_data.sa_value[lsm_pkg::VAL_BITS-1:0];
      rem      <= '0;
      step     <= '0;
      blk_last <= in_data.block_last;
    end else if (cmd.div_step) begin
      quo  <= {quo[lsm_pkg::VAL_BITS-2:0], fits};
      rem  <= rem_step;
      step <= step + lsm_pkg::STEP_BITS'(1);
    end
  end

  // record store
  always_ff @(posedge clk) begin
    if (cmd.mark_emit && store) begin
      mem[record_count[lsm_pkg::IDX_BITS-1:0]] <= '{offset: item_index, quotient: quo_ext};
    end
    if (cmd.drain_read) begin
      rd_data <= mem[rd_idx[lsm_pkg::IDX_BITS-1:0]];
    end
  end

  // block counters
  always_ff @(posedge clk) begin
    if (rst) begin
      item_index   <= '0;
      record_count <= '0;
      rd_idx       <= '0;
    end else if (cmd.mark_emit) begin
      if (closing && count_add == '0) begin
        item_index   <= '0;
        record_count <= '0;
      end else begin
        record_count <= count_add;
        if (!closing) begin
          item_index <= item_index + lsm_pkg::OFF_BITS'(1);
        end
      end
    end else if (cmd.drain_emit) begin
      if (status.drain_last) begin
        item_index   <= '0;
        record_count <= '0;
        rd_idx       <= '0;
      end else begin
        rd_idx <= rd_idx + lsm_pkg::CNT_BITS'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.mark_emit || cmd.drain_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark_emit) begin
      out_data.kind        <= lsm_pkg::KIND_MARK;
      out_data.mark_bit    <= marked;
      out_data.bwt_offset  <= '0;
      out_data.orig_sample <= '0;
      out_data.last        <= !closing || (count_add == '0);
    end else if (cmd.drain_emit) begin
      out_data.kind        <= lsm_pkg::KIND_RECORD;
      out_data.mark_bit    <= 1'b0;
      out_data.bwt_offset  <= rd_data.offset;
      out_data.orig_sample <= rd_data.quotient;
      out_data.last        <= status.drain_last;
    end
  end

endmodule
`default_nettype wire

@@ rtl/locate_sample_marker.sv @@
// Flow: an item is loaded and divided at one quotient bit per cycle; its mark result is
// registered from S_MARK once the output is free. No new item is taken before S_IDLE;
// a closing item first drains each stored record: one store read, one output transfer.
// Reset: synchronous; clears the controller, block counters and output valid, and sets
// sample_interval to 32. Record store contents are not cleared and need no clearing pass.
`default_nettype none
module locate_sample_marker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire lsm_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output lsm_pkg::out_t                      out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lsm_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [lsm_pkg::DATA_BITS-1:0] pwdata,
  output logic [lsm_pkg::DATA_BITS-1:0]      prdata,
  output logic                               pready
);

  logic [lsm_pkg::DATA_BITS-1:0] sample_interval;
  lsm_pkg::cmd_t                 cmd;
  lsm_pkg::status_t              status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval <= lsm_pkg::SAMPLE_INTERVAL_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[lsm_pkg::ADDR_BITS-1] == lsm_pkg::REG_SAMPLE_INTERVAL) begin
      sample_interval <= pwdata;
    end
  end

  always_comb begin
    unique case (paddr[lsm_pkg::ADDR_BITS-1])
      lsm_pkg::REG_SAMPLE_INTERVAL: prdata = sample_interval;
      default:                      prdata = '0;
    endcase
  end

  lsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lsm_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_data         (in_data),
    .sample_interval (sample_interval),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data)
  );

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Testbench for locate_sample_marker: directed and random blocks checked by a predictor.
`timescale 1ns / 100ps
module tb;

  localparam int CLK_HALF      = 4;
  localparam int MARK_LATENCY  = lsm_pkg::VAL_BITS + 2;
  localparam int SETTLE_CYCLES = 2 * MARK_LATENCY;
  localparam int HOLD_CYCLES   = 700;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int IDLE_PCT      = 22;
  localparam int MAX_REPORTS   = 10;
  localparam int REG_UNUSED    = 1;
  localparam int PHASE_ITEMS   = 18;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  lsm_pkg::in_t                  in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  lsm_pkg::out_t                 out_data;
  logic                          psel      = 1'b0;
  logic                          penable   = 1'b0;
  logic                          pwrite    = 1'b0;
  logic [lsm_pkg::ADDR_BITS-1:0] paddr     = '0;
  logic [lsm_pkg::DATA_BITS-1:0] pwdata    = '0;
  logic [lsm_pkg::DATA_BITS-1:0] prdata;
  logic                          pready;

  // predicted block state
  logic [lsm_pkg::DATA_BITS-1:0] interval  = lsm_pkg::SAMPLE_INTERVAL_RESET;
  int unsigned                   blk_pos   = 0;
  int unsigned                   rec_count = 0;
  lsm_pkg::record_t              rec_store [lsm_pkg::BLOCK_LEN];
  lsm_pkg::out_t                 pending_results [$];

  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          rx_holding = 1'b0;
  event        hold_off_ev;

  locate_sample_marker i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_holding) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rx_idle_en || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always begin
    @(hold_off_ev);
    rx_holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_holding <= 1'b0;
  end

  always @(posedge clk) begin
    lsm_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with none expected: kind=%0d mark=%0d off=%0d sample=%h last=%0d",
                   $time, out_data.kind, out_data.mark_bit, out_data.bwt_offset,
                   out_data.orig_sample, out_data.last);
      end else begin
        want = pending_results.pop_front();
        if (out_data.kind !== want.kind || out_data.mark_bit !== want.mark_bit ||
            out_data.bwt_offset !== want.bwt_offset ||
            out_data.orig_sample !== want.orig_sample || out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: expected kind=%0d mark=%0d off=%0d sample=%h last=%0d",
                     $time, want.kind, want.mark_bit, want.bwt_offset, want.orig_sample,
                     want.last);
            $display("%0t:      got kind=%0d mark=%0d off=%0d sample=%h last=%0d",
                     $time, out_data.kind, out_data.mark_bit, out_data.bwt_offset,
                     out_data.orig_sample, out_data.last);
          end
        end
      end
    end
  end

  function automatic void predict_marks(lsm_pkg::in_t item);
    logic sampled;
    logic closing;
    lsm_pkg::out_t r;
    sampled = 1'b0;
    if (interval != 0)
      sampled = (item.sa_value % interval) == 0;
    if (sampled && rec_count < lsm_pkg::BLOCK_LEN) begin
      rec_store[rec_count].offset   = lsm_pkg::OFF_BITS'(blk_pos);
      rec_store[rec_count].quotient = item.sa_value / interval;
      rec_count++;
    end
    closing = item.block_last || (blk_pos + 1 >= lsm_pkg::BLOCK_LEN);
    r = '0;
    r.kind     = lsm_pkg::KIND_MARK;
    r.mark_bit = sampled;
    r.last     = !closing || rec_count == 0;
    pending_results.push_back(r);
    if (closing) begin
      for (int i = 0; i < rec_count; i++) begin
        r = '0;
        r.kind        = lsm_pkg::KIND_RECORD;
        r.bwt_offset  = rec_store[i].offset;
        r.orig_sample = rec_store[i].quotient;
        r.last        = (i + 1 == rec_count);
        pending_results.push_back(r);
      end
      blk_pos   = 0;
      rec_count = 0;
    end else begin
      blk_pos = (blk_pos + 1) % 64;
    end
  endfunction

  function automatic logic [lsm_pkg::DATA_BITS-1:0] pick_value();
    int unsigned       sel;
    longint unsigned   max_k;
    longint unsigned   k;
    sel = $urandom_range(99);
    if (sel < 5)
      return '0;
    if (sel < 10)
      return '1;
    if (sel < 55 && interval != 0) begin
      max_k = 64'hFFFF_FFFF / interval;
      k = $urandom_range(1) ? $urandom_range(0, 40) : $urandom;
      return lsm_pkg::DATA_BITS'((k % (max_k + 1)) * interval);
    end
    return $urandom;
  endfunction

  task automatic send_entry(logic [lsm_pkg::DATA_BITS-1:0] value, logic blk_last);
    lsm_pkg::in_t item;
    item.sa_value   = value;
    item.block_last = blk_last;
    if (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    predict_marks(item);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(int unsigned idx, logic [lsm_pkg::DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lsm_pkg::ADDR_BITS'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == int'(lsm_pkg::REG_SAMPLE_INTERVAL))
      interval = value;
  endtask

  task automatic check_interval_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= lsm_pkg::ADDR_BITS'(int'(lsm_pkg::REG_SAMPLE_INTERVAL) * 4);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== interval) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: sample_interval read expected %h got %h", $time, interval, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_interval(logic [lsm_pkg::DATA_BITS-1:0] value);
    settle_block();
    apb_write(int'(lsm_pkg::REG_SAMPLE_INTERVAL), value);
    check_interval_reg();
  endtask

  task automatic send_random_blocks(int unsigned n);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n) begin
      len = ($urandom_range(99) < 10) ? $urandom_range(33, 40) : $urandom_range(1, 12);
      for (int k = 0; k < len; k++)
        send_entry(pick_value(), (k == len - 1) || ($urandom_range(99) < 3));
      sent += len;
    end
  endtask

  task automatic test_reset_value();
    check_interval_reg();
  endtask

  task automatic test_directed();
    // reset interval: zero, non-multiple, multiple, top multiple
    send_entry(32'd0, 1'b0);
    send_entry(32'd31, 1'b0);
    send_entry(32'd32, 1'b0);
    send_entry(32'hFFFF_FFE0, 1'b1);
    send_entry(32'd1, 1'b1);
    // zero interval samples nothing
    set_interval(32'd0);
    send_entry(32'd0, 1'b0);
    send_entry(32'hFFFF_FFFF, 1'b1);
    // write to an unmapped register is dropped
    settle_block();
    apb_write(REG_UNUSED, 32'd7);
    check_interval_reg();
    set_interval(32'd1);
    send_entry(32'hFFFF_FFFF, 1'b0);
    send_entry(32'd0, 1'b1);
    set_interval(32'hFFFF_FFFF);
    send_entry(32'hFFFF_FFFF, 1'b0);
    send_entry(32'hFFFF_FFFE, 1'b0);
    send_entry(32'd0, 1'b1);
    set_interval(32'd3);
    send_entry(32'd9, 1'b0);
    send_entry(32'd10, 1'b0);
    send_entry(32'h8000_0001, 1'b1);
  endtask

  task automatic test_forced_close();
    set_interval(32'd1);
    for (int k = 0; k < 40; k++)
      send_entry($urandom, k == 39);
  endtask

  task automatic test_backpressure();
    set_interval(32'd2);
    tx_idle_en = 1'b0;
    -> hold_off_ev;
    for (int k = 0; k < 36; k++)
      send_entry($urandom & ~32'd1, k == 35);
    settle_block();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_phases();
    logic [lsm_pkg::DATA_BITS-1:0] settings [10];
    settings = '{32'd1, 32'd2, 32'd3, 32'd7, 32'd32, 32'd1000, 32'h8000_0000,
                 32'hFFFF_FFFF, 32'd0, 32'd0};
    settings[9] = $urandom_range(1) ? $urandom : $urandom_range(1, 64);
    foreach (settings[p]) begin
      set_interval(settings[p]);
      // one phase runs both sides at full rate
      tx_idle_en = (p != 4);
      rx_idle_en <= (p != 4);
      send_random_blocks(PHASE_ITEMS);
    end
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_value();
    test_directed();
    test_forced_close();
    test_backpressure();
    test_random_phases();
    settle_block();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
